// ----- design/swtmr_pkg.sv -----
// Shared types and constants for the software timer slot table.
// Holds the request/response words and the token that runs down the cell chain.
// No dependencies.
package swtmr_pkg;

	localparam int SLOTS = 10;
	localparam int TIME_BITS = 32;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] now;
		logic [15:0] after;
	} req_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic        busy_res;
		logic [9:0]  fired_mask;
		logic        stop_timer;
		logic        reprogram;
		logic [31:0] delay;
	} rsp_t;

	// token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic              valid;
		logic              mode;
		time_t             now;
		time_t             expiry;
		logic [SLOT_W-1:0] idx;
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic              earlier;
		logic              pending;
		time_t             next;
		logic [SLOTS-1:0]  fired;
	} chain_t;

endpackage

// ----- design/swtmr_cell.sv -----
// One slot of the timer table: holds one expiry and updates the passing token.
// Depends on swtmr_pkg.
module swtmr_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  swtmr_pkg::chain_t carry_in,
	output swtmr_pkg::chain_t carry_out
);
	import swtmr_pkg::*;

	time_t  entry_q;
	time_t  entry_d;
	chain_t carry_d;
	chain_t carry_q;
	logic   fire;

	always_comb begin
		carry_d = carry_in;
		entry_d = entry_q;
		fire = 1'b0;
		if (carry_in.valid) begin
			if (carry_in.mode == MODE_ADD) begin
				if (!carry_in.found && entry_q == '0) begin
					entry_d = carry_in.expiry;
					carry_d.found = 1'b1;
					carry_d.slot = carry_in.idx;
				end
				if (entry_q != '0 && entry_q < carry_in.expiry) begin
					carry_d.earlier = 1'b1;
				end
			end else begin
				if (entry_q != '0) begin
					if (entry_q <= carry_in.now) begin
						entry_d = '0;
						fire = 1'b1;
					end else if (!carry_in.pending || entry_q < carry_in.next) begin
						carry_d.pending = 1'b1;
						carry_d.next = entry_q;
					end
				end
			end
		end
		carry_d.idx = carry_in.idx + SLOT_W'(1);
		// fired bits shift down; after the last cell bit i belongs to slot i
		carry_d.fired = (carry_in.fired >> 1) | (SLOTS'(fire) << (SLOTS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			carry_q <= '0;
		end else begin
			entry_q <= entry_d;
			carry_q <= carry_d;
		end
	end

	assign carry_out = carry_q;

endmodule

// ----- design/software_timer_slot_table.sv -----
// Software timer slot table: one hardware one-shot timer shared by SLOTS slots.
// Path: an accepted request word passes the slot cell registers, then the tail
// register and the response register. A new request is taken only once the
// response word is loaded; one token walks the chain one cell per cycle.
// Reset: asynchronous, clears every slot to free and empties chain and output.
module software_timer_slot_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  swtmr_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output swtmr_pkg::rsp_t rsp
);
	import swtmr_pkg::*;

	chain_t carry [0:SLOTS];
	chain_t tail_q;
	logic   tail_valid_q;
	logic   busy_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;
	rsp_t   rsp_d;
	logic   accept;
	logic   load;
	logic [TIME_BITS:0] sum;
	time_t  now_t;
	time_t  exp_t;
	time_t  diff;
	logic [SLOTS:0] chain_valid;

	assign accept = req_valid && !req_stall;
	assign req_stall = busy_q;

	// expiry = now + after, saturated, never zero
	always_comb begin
		now_t = TIME_BITS'(req.now);
		sum = {1'b0, now_t} + (TIME_BITS + 1)'(req.after);
		exp_t = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
		if (exp_t == '0) begin
			exp_t = TIME_BITS'(1);
		end
		carry[0].valid = accept;
		carry[0].mode = req.mode;
		carry[0].now = now_t;
		carry[0].expiry = exp_t;
		carry[0].idx = '0;
		carry[0].found = 1'b0;
		carry[0].slot = '0;
		carry[0].earlier = 1'b0;
		carry[0].pending = 1'b0;
		carry[0].next = '0;
		carry[0].fired = '0;
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		swtmr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.carry_in (carry[i]),
			.carry_out(carry[i+1])
		);
	end

	for (genvar i = 0; i <= SLOTS; i++) begin : g_vld
		assign chain_valid[i] = carry[i].valid;
	end

	assign load = tail_valid_q && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tail_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (carry[SLOTS].valid) begin
				tail_valid_q <= 1'b1;
			end else if (load) begin
				tail_valid_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (carry[SLOTS].valid) begin
			tail_q <= carry[SLOTS];
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	// response word from the token leaving the last cell
	always_comb begin
		rsp_d = '0;
		if (tail_q.mode == MODE_ADD) begin
			diff = tail_q.expiry - tail_q.now;
			if (!tail_q.found) begin
				rsp_d.busy_res = 1'b1;
			end else begin
				rsp_d.slot = 4'(tail_q.slot);
				rsp_d.reprogram = !tail_q.earlier;
			end
		end else begin
			diff = tail_q.next - tail_q.now;
			rsp_d.fired_mask = 10'(tail_q.fired);
			rsp_d.stop_timer = 1'b1;
			rsp_d.reprogram = tail_q.pending;
		end
		if (rsp_d.reprogram) begin
			rsp_d.delay = (64'(diff) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(diff);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chain_valid, tail_valid_q}))
		else $error("more than one token in the slot chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (chain_valid[SLOTS:1] == '0 && !tail_valid_q))
		else $error("token in chain while not busy");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_q))
		else $error("response word without a request in flight");

	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.stop_timer |-> !rsp_q.busy_res && rsp_q.slot == 4'd0)
		else $error("tick response carries add fields");
`endif

endmodule
